[sv/tcd_pkg.sv]
// ----------------------------------------------------------------------------
// Two-tooth crank decoder package
// Shared types and constants for the decoder, tooth tracker and divider.
// ----------------------------------------------------------------------------
package tcd_pkg;

  // Field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned FILT_W   = 16;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned ANGLE_W  = 8;
  localparam int unsigned RPM_W    = 16;
  localparam int unsigned LOSS_W   = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Dividend width: largest dividend is the revolution numerator (< 2^26)
  localparam int unsigned NUM_W    = 26;
  localparam int unsigned STEP_W   = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TIME   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRANK_RPM_THR = 1'd1;

  // Reset values of the registers
  localparam logic [FILT_W-1:0] FILTER_RESET    = 16'd1500;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 15'd400;

  // Tooth codes
  localparam logic [1:0] TOOTH_NONE   = 2'd0;
  localparam logic [1:0] TOOTH_SYNC   = 2'd1;
  localparam logic [1:0] TOOTH_SECOND = 2'd2;

  localparam logic [ANGLE_W-1:0] SECOND_TOOTH_ANGLE = 8'd157;

  // Cranking numerator: floor(157 * 6000000 / 36); the 36 folds out of the
  // divisor since floor(floor(n/a)/b) == floor(n/(a*b)).
  localparam logic [NUM_W-1:0] CRANK_NUM = 26'd26166666;
  // Running numerator: 60e6 us per minute
  localparam logic [NUM_W-1:0] REV_NUM   = 26'd60000000;

  localparam logic [RPM_W-1:0] RPM_MAX = 16'hFFFF;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_OUT
  } tcd_state_t;

  // Tracker status handed to the sequencer
  typedef struct packed {
    logic               valid_tooth;
    logic [1:0]         tooth_index;
    logic               sync;
    logic [ANGLE_W-1:0] angle;
    logic [LOSS_W-1:0]  losses;
    logic [COUNT_W-1:0] teeth;
    logic               two_teeth;
    logic [TIME_W-1:0]  tooth_gap;
    logic [TIME_W-1:0]  rev_gap;
  } tcd_track_t;

endpackage

[sv/tcd_if.sv]
// ----------------------------------------------------------------------------
// Two-tooth crank decoder channels
// Valid/ready interfaces for trigger edges and decoder results.
// ----------------------------------------------------------------------------
interface tcd_in_if;
  logic                       valid;
  logic                       ready;
  logic [tcd_pkg::TIME_W-1:0] edge_time_us;
  logic                       pin_level;

  modport source (output valid, output edge_time_us, output pin_level, input ready);
  modport sink   (input valid, input edge_time_us, input pin_level, output ready);
endinterface

interface tcd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        valid_tooth;
  logic [1:0]                  tooth_number;
  logic                        in_sync;
  logic [tcd_pkg::ANGLE_W-1:0] tooth_angle;
  logic [tcd_pkg::RPM_W-1:0]   engine_rpm;
  logic [tcd_pkg::LOSS_W-1:0]  sync_losses;
  logic [tcd_pkg::COUNT_W-1:0] revolution_count;

  modport source (output valid, output valid_tooth, output tooth_number, output in_sync,
                  output tooth_angle, output engine_rpm, output sync_losses,
                  output revolution_count, input ready);
  modport sink   (input valid, input valid_tooth, input tooth_number, input in_sync,
                  input tooth_angle, input engine_rpm, input sync_losses,
                  input revolution_count, output ready);
endinterface

[sv/tcd_track.sv]
// ----------------------------------------------------------------------------
// Tooth tracker
// Keeps gap history, tooth timestamps, sync and counters; updates per edge.
// ----------------------------------------------------------------------------
module tcd_track (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic [tcd_pkg::TIME_W-1:0]    edge_time,
  input  logic                          level,
  input  logic [tcd_pkg::FILT_W-1:0]    filter_time,
  output tcd_pkg::tcd_track_t           status
);

  logic [tcd_pkg::TIME_W-1:0]  last_tooth_r, last_tooth_nxt;
  logic [tcd_pkg::TIME_W-1:0]  prior_tooth_r, prior_tooth_nxt;
  logic [tcd_pkg::TIME_W-1:0]  cur_gap_r, cur_gap_nxt;
  logic [tcd_pkg::TIME_W-1:0]  sync_time_r, sync_time_nxt;
  logic [tcd_pkg::TIME_W-1:0]  prior_sync_r, prior_sync_nxt;
  logic [1:0]                  idx_r, idx_nxt;
  logic                        sync_r, sync_nxt;
  logic [tcd_pkg::ANGLE_W-1:0] angle_r, angle_nxt;
  logic [tcd_pkg::LOSS_W-1:0]  loss_r, loss_nxt;
  logic [tcd_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [1:0]                  seen_r, seen_nxt;
  logic                        vt_r, vt_nxt;
  logic [tcd_pkg::TIME_W-1:0]  gap;

  // Work out the new state for one edge
  always_comb begin
    last_tooth_nxt  = last_tooth_r;
    prior_tooth_nxt = prior_tooth_r;
    cur_gap_nxt     = cur_gap_r;
    sync_time_nxt   = sync_time_r;
    prior_sync_nxt  = prior_sync_r;
    idx_nxt         = idx_r;
    sync_nxt        = sync_r;
    angle_nxt       = angle_r;
    loss_nxt        = loss_r;
    count_nxt       = count_r;
    seen_nxt        = seen_r;
    vt_nxt          = vt_r;
    gap             = edge_time - last_tooth_r;
    if (upd) begin
      cur_gap_nxt = gap;
      vt_nxt      = 1'b0;
      if (gap > {{(tcd_pkg::TIME_W-tcd_pkg::FILT_W){1'b0}}, filter_time}) begin
        if (level) begin
          vt_nxt = 1'b1;
          // Longer gap than the one before marks the sync tooth
          if (gap > cur_gap_r) begin
            idx_nxt        = tcd_pkg::TOOTH_SYNC;
            angle_nxt      = '0;
            prior_sync_nxt = sync_time_r;
            sync_time_nxt  = edge_time;
            sync_nxt       = 1'b1;
          end else begin
            idx_nxt   = tcd_pkg::TOOTH_SECOND;
            angle_nxt = tcd_pkg::SECOND_TOOTH_ANGLE;
          end
          prior_tooth_nxt = last_tooth_r;
          last_tooth_nxt  = edge_time;
          count_nxt       = count_r + 1'b1;
          if (seen_r != 2'd2) begin
            seen_nxt = seen_r + 1'b1;
          end
        end else begin
          // Low edge past the filter drops sync
          if (sync_r) begin
            loss_nxt = loss_r + 1'b1;
          end
          sync_nxt = 1'b0;
          idx_nxt  = tcd_pkg::TOOTH_NONE;
        end
      end
    end
  end

  // Hold tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tooth_r  <= '0;
      prior_tooth_r <= '0;
      cur_gap_r     <= '0;
      sync_time_r   <= '0;
      prior_sync_r  <= '0;
      idx_r         <= tcd_pkg::TOOTH_NONE;
      sync_r        <= 1'b0;
      angle_r       <= '0;
      loss_r        <= '0;
      count_r       <= '0;
      seen_r        <= '0;
      vt_r          <= 1'b0;
    end else begin
      last_tooth_r  <= last_tooth_nxt;
      prior_tooth_r <= prior_tooth_nxt;
      cur_gap_r     <= cur_gap_nxt;
      sync_time_r   <= sync_time_nxt;
      prior_sync_r  <= prior_sync_nxt;
      idx_r         <= idx_nxt;
      sync_r        <= sync_nxt;
      angle_r       <= angle_nxt;
      loss_r        <= loss_nxt;
      count_r       <= count_nxt;
      seen_r        <= seen_nxt;
      vt_r          <= vt_nxt;
    end
  end

  // Report status
  always_comb begin
    status.valid_tooth = vt_r;
    status.tooth_index = idx_r;
    status.sync        = sync_r;
    status.angle       = angle_r;
    status.losses      = loss_r;
    status.teeth       = count_r;
    status.two_teeth   = (seen_r == 2'd2);
    status.tooth_gap   = last_tooth_r - prior_tooth_r;
    status.rev_gap     = sync_time_r - prior_sync_r;
  end

endmodule

[sv/tcd_div.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle; zero divisor gives zero.
// ----------------------------------------------------------------------------
module tcd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tcd_pkg::NUM_W-1:0]   num,
  input  logic [tcd_pkg::TIME_W-1:0]  den,
  output logic                        done,
  output logic [tcd_pkg::NUM_W-1:0]   quot
);

  logic                        busy_r, busy_nxt;
  logic [tcd_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [tcd_pkg::NUM_W-1:0]   qn_r, qn_nxt;
  logic [tcd_pkg::TIME_W:0]    rem_r, rem_nxt;
  logic [tcd_pkg::TIME_W-1:0]  den_r, den_nxt;
  logic                        zero_r, zero_nxt;
  logic                        done_r, done_nxt;
  logic [tcd_pkg::TIME_W:0]    trial;

  // One shift-and-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    qn_nxt   = qn_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    trial    = {rem_r[tcd_pkg::TIME_W-1:0], qn_r[tcd_pkg::NUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      qn_nxt   = num;
      rem_nxt  = '0;
      den_nxt  = den;
      zero_nxt = (den == '0);
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        qn_nxt  = {qn_r[tcd_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        qn_nxt  = {qn_r[tcd_pkg::NUM_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == tcd_pkg::STEP_W'(tcd_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qn_r   <= qn_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    zero_r <= zero_nxt;
  end

  assign done = done_r;
  assign quot = zero_r ? '0 : qn_r;

endmodule

[sv/two_tooth_uneven_crank_decoder.sv]
// ----------------------------------------------------------------------------
// Two-tooth uneven crank trigger decoder
// Tracks teeth and sync per trigger edge and reports rpm from a serial divider.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+----------------------------------------------------
//  in_ch    | sink      | edge_time_us[31:0], pin_level
//  out_ch   | source    | valid_tooth, tooth_number, in_sync, tooth_angle,
//           |           | engine_rpm, sync_losses, revolution_count
//  cfg_*    | write     | 0 filter_time_us, 1 crank_rpm_threshold
//
// Each edge goes through accept, divider setup, 26 divider steps (one
// quotient bit each from the shared subtractor), taking the rpm and loading
// the result register. Reset is synchronous; it clears all tracker state and
// loads the register defaults. in_ch.ready is high only while idle;
// the next edge is taken while a result still waits for out_ch.ready, and the
// sequencer stalls before the result register until it is free.
// ----------------------------------------------------------------------------
module two_tooth_uneven_crank_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  tcd_in_if.sink                          in_ch,
  tcd_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [tcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcd_pkg::CFG_W-1:0]       cfg_data
);

  tcd_pkg::tcd_state_t          state_r, state_nxt;
  logic [tcd_pkg::FILT_W-1:0]   filter_r;
  logic [tcd_pkg::THR_W-1:0]    thr_r;
  logic [tcd_pkg::RPM_W-1:0]    last_rpm_r, last_rpm_nxt;
  logic                         ovalid_r, ovalid_nxt;
  logic                         load_out;
  logic                         accept;
  logic                         div_start;
  logic                         div_done;
  logic [tcd_pkg::NUM_W-1:0]    div_num;
  logic [tcd_pkg::TIME_W-1:0]   div_den;
  logic [tcd_pkg::NUM_W-1:0]    div_quot;
  logic [tcd_pkg::RPM_W-1:0]    rpm_sat;
  logic                         crank_mode;
  tcd_pkg::tcd_track_t          trk;

  logic                         o_vt_r;
  logic [1:0]                   o_idx_r;
  logic                         o_sync_r;
  logic [tcd_pkg::ANGLE_W-1:0]  o_angle_r;
  logic [tcd_pkg::RPM_W-1:0]    o_rpm_r;
  logic [tcd_pkg::LOSS_W-1:0]   o_loss_r;
  logic [tcd_pkg::COUNT_W-1:0]  o_count_r;

  assign in_ch.ready = (state_r == tcd_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= tcd_pkg::FILTER_RESET;
      thr_r    <= tcd_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tcd_pkg::REG_FILTER_TIME:   filter_r <= cfg_data;
        tcd_pkg::REG_CRANK_RPM_THR: thr_r    <= cfg_data[tcd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  tcd_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (accept),
    .edge_time   (in_ch.edge_time_us),
    .level       (in_ch.pin_level),
    .filter_time (filter_r),
    .status      (trk)
  );

  // Pick dividend and divisor for the rpm rule
  always_comb begin
    crank_mode = ({1'b0, last_rpm_r} < {2'b00, thr_r});
    if (!trk.sync) begin
      div_num = '0;
    end else if (crank_mode) begin
      div_num = (trk.two_teeth && (trk.angle != '0)) ? tcd_pkg::CRANK_NUM : '0;
    end else begin
      div_num = tcd_pkg::REV_NUM;
    end
    div_den = crank_mode ? trk.tooth_gap : trk.rev_gap;
  end

  tcd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Saturate the quotient to the rpm width
  assign rpm_sat = (div_quot[tcd_pkg::NUM_W-1:tcd_pkg::RPM_W] != '0) ?
                   tcd_pkg::RPM_MAX : div_quot[tcd_pkg::RPM_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    last_rpm_nxt = last_rpm_r;
    ovalid_nxt   = ovalid_r;
    div_start    = 1'b0;
    load_out     = 1'b0;
    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      tcd_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = tcd_pkg::ST_SETUP;
        end
      end
      tcd_pkg::ST_SETUP: begin
        div_start = 1'b1;
        state_nxt = tcd_pkg::ST_DIV;
      end
      tcd_pkg::ST_DIV: begin
        if (div_done) begin
          last_rpm_nxt = rpm_sat;
          state_nxt    = tcd_pkg::ST_OUT;
        end
      end
      tcd_pkg::ST_OUT: begin
        // Hold until the result register is free
        if (!ovalid_r || out_ch.ready) begin
          load_out   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = tcd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tcd_pkg::ST_IDLE;
      last_rpm_r <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      last_rpm_r <= last_rpm_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_vt_r    <= trk.valid_tooth;
      o_idx_r   <= trk.tooth_index;
      o_sync_r  <= trk.sync;
      o_angle_r <= trk.angle;
      o_rpm_r   <= last_rpm_r;
      o_loss_r  <= trk.losses;
      o_count_r <= trk.teeth;
    end
  end

  assign out_ch.valid            = ovalid_r;
  assign out_ch.valid_tooth      = o_vt_r;
  assign out_ch.tooth_number     = o_idx_r;
  assign out_ch.in_sync          = o_sync_r;
  assign out_ch.tooth_angle      = o_angle_r;
  assign out_ch.engine_rpm       = o_rpm_r;
  assign out_ch.sync_losses      = o_loss_r;
  assign out_ch.revolution_count = o_count_r;

endmodule
